// ===== rtl/v4alu_pkg.sv =====
// ----------------------------------------------------------------------------
// v4alu_pkg: shared types and constants of the four-component vector unit
// Item layouts, opcodes, word widths, pipeline stage numbers and saturation.
// ----------------------------------------------------------------------------
package v4alu_pkg;

    localparam int QW         = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = 2 * QW;
    localparam int DIFF_BITS  = PROD_BITS + 1;
    localparam int SUM_BITS   = PROD_BITS + 3;
    localparam int SAT_BITS   = PROD_BITS + 4;
    localparam int ROOT_BITS  = QW;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int NUM_BITS   = QW + FRAC_BITS;
    localparam int DEN_BITS   = ROOT_BITS + 1 + FRAC_BITS;

    // stage numbers, counted in registers after acceptance
    localparam int ST_LANE = 4;
    localparam int ST_DOT  = 5;
    localparam int ST_ROOT = ST_LANE + ROOT_BITS;
    localparam int ST_LAST = ST_ROOT + DIV_STEPS;

    localparam logic signed [SAT_BITS-1:0] QMAX = SAT_BITS'((65'sd1 <<< (QW - 1)) - 65'sd1);
    localparam logic signed [SAT_BITS-1:0] QMIN = -QMAX - SAT_BITS'(1);

    typedef enum logic [2:0] {
        CMD_SCALE = 3'd0,
        CMD_ADD   = 3'd1,
        CMD_SUB   = 3'd2,
        CMD_MAG   = 3'd3,
        CMD_NORM  = 3'd4,
        CMD_DOT   = 3'd5,
        CMD_CROSS = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [2:0]            cmd;
        logic signed [QW-1:0]  a_x;
        logic signed [QW-1:0]  a_y;
        logic signed [QW-1:0]  a_z;
        logic signed [QW-1:0]  a_w;
        logic signed [QW-1:0]  b_x;
        logic signed [QW-1:0]  b_y;
        logic signed [QW-1:0]  b_z;
        logic signed [QW-1:0]  b_w;
        logic signed [QW-1:0]  scalar_in;
    } op_t;

    typedef struct packed {
        logic signed [QW-1:0]  r_x;
        logic signed [QW-1:0]  r_y;
        logic signed [QW-1:0]  r_z;
        logic signed [QW-1:0]  r_w;
        logic signed [QW-1:0]  r_scalar;
        logic                  overflow_flag;
        logic                  divide_flag;
    } res_t;

    typedef struct packed {
        logic signed [QW-1:0]  val;
        logic                  ovf;
    } sat_t;

    function automatic sat_t sat_q(input logic signed [SAT_BITS-1:0] v);
        sat_t r;
        if (v > QMAX)
        begin
            r.val = QW'(QMAX);
            r.ovf = 1'b1;
        end
        else if (v < QMIN)
        begin
            r.val = QW'(QMIN);
            r.ovf = 1'b1;
        end
        else
        begin
            r.val = QW'(v);
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/v4alu_lane.sv =====
// ----------------------------------------------------------------------------
// v4alu_lane: one product lane
// Two signed products, their difference, and the scaled saturated result.
// ----------------------------------------------------------------------------
module v4alu_lane
(
    input  logic                                     clk,
    input  logic                                     en,
    input  logic signed [v4alu_pkg::QW-1:0]          x0,
    input  logic signed [v4alu_pkg::QW-1:0]          y0,
    input  logic signed [v4alu_pkg::QW-1:0]          x1,
    input  logic signed [v4alu_pkg::QW-1:0]          y1,
    output logic signed [v4alu_pkg::DIFF_BITS-1:0]   diff,
    output v4alu_pkg::sat_t                          res
);

    logic signed [v4alu_pkg::PROD_BITS-1:0] p0_reg, p0_next;
    logic signed [v4alu_pkg::PROD_BITS-1:0] p1_reg, p1_next;
    logic signed [v4alu_pkg::DIFF_BITS-1:0] d_reg, d_next;
    logic signed [v4alu_pkg::DIFF_BITS-1:0] d_shr;
    v4alu_pkg::sat_t                        res_reg, res_next;

    always_comb
    begin
        p0_next  = v4alu_pkg::PROD_BITS'(x0) * v4alu_pkg::PROD_BITS'(y0);
        p1_next  = v4alu_pkg::PROD_BITS'(x1) * v4alu_pkg::PROD_BITS'(y1);
        d_next   = v4alu_pkg::DIFF_BITS'(p0_reg) - v4alu_pkg::DIFF_BITS'(p1_reg);
        // floor scaling of the exact difference
        d_shr    = d_reg >>> v4alu_pkg::FRAC_BITS;
        res_next = v4alu_pkg::sat_q(v4alu_pkg::SAT_BITS'(d_shr));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            d_reg   <= d_next;
            res_reg <= res_next;
        end
    end

    assign diff = d_reg;
    assign res  = res_reg;

endmodule

// ===== rtl/v4alu_sqrt.sv =====
// ----------------------------------------------------------------------------
// v4alu_sqrt: pipelined integer square root
// One root bit per stage, restoring digit-by-digit method.
// ----------------------------------------------------------------------------
module v4alu_sqrt
(
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [2*v4alu_pkg::ROOT_BITS:0]       op,
    output logic [v4alu_pkg::ROOT_BITS:0]         root
);

    localparam int RB = v4alu_pkg::ROOT_BITS;

    logic [RB+1:0]   rem_reg  [RB];
    logic [RB-1:0]   root_reg [RB];
    logic [2*RB-1:0] op_reg   [RB];
    logic            big_reg  [RB];

    for (genvar j = 0; j < RB; j++)
    begin : g_stage
        localparam int K = RB - 1 - j;
        logic [RB+1:0]   rem_in, rem_next;
        logic [RB-1:0]   root_in, root_next;
        logic [2*RB-1:0] op_in;
        logic            big_in;
        logic [RB+3:0]   rem_sh, trial;

        if (j == 0)
        begin : g_head
            assign rem_in  = '0;
            assign root_in = '0;
            assign op_in   = op[2*RB-1:0];
            assign big_in  = op[2*RB];
        end
        else
        begin : g_body
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign op_in   = op_reg[j-1];
            assign big_in  = big_reg[j-1];
        end

        always_comb
        begin
            rem_sh = {rem_in, op_in[2*K +: 2]};
            trial  = (RB+4)'({root_in, 2'b01});
            if (rem_sh >= trial)
            begin
                rem_next  = (RB+2)'(rem_sh - trial);
                root_next = {root_in[RB-2:0], 1'b1};
            end
            else
            begin
                rem_next  = (RB+2)'(rem_sh);
                root_next = {root_in[RB-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                op_reg[j]   <= op_in;
                big_reg[j]  <= big_in;
            end
        end
    end

    // a sum of squares that reaches 2^64 has root 2^32
    assign root = big_reg[RB-1] ? {1'b1, {RB{1'b0}}} : {1'b0, root_reg[RB-1]};

endmodule

// ===== rtl/v4alu_div.sv =====
// ----------------------------------------------------------------------------
// v4alu_div: pipelined fractional divider
// Quotient of (num << FRAC_BITS) / den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module v4alu_div
(
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [v4alu_pkg::QW-1:0]              num,
    input  logic [v4alu_pkg::ROOT_BITS:0]         den,
    output logic [v4alu_pkg::DIV_STEPS-1:0]       quo
);

    localparam int NS = v4alu_pkg::DIV_STEPS;
    localparam int NB = v4alu_pkg::NUM_BITS;
    localparam int DB = v4alu_pkg::DEN_BITS;
    localparam int RB = v4alu_pkg::ROOT_BITS;

    logic [NB-1:0] rem_reg [NS];
    logic [NS-1:0] q_reg   [NS];
    logic [RB:0]   m_reg   [NS];

    for (genvar j = 0; j < NS; j++)
    begin : g_stage
        localparam int K = NS - 1 - j;
        logic [NB-1:0] rem_in, rem_next;
        logic [NS-1:0] q_in, q_next;
        logic [RB:0]   m_in;
        logic [DB-1:0] rem_ext, tsub;

        if (j == 0)
        begin : g_head
            assign rem_in = {num, {v4alu_pkg::FRAC_BITS{1'b0}}};
            assign q_in   = '0;
            assign m_in   = den;
        end
        else
        begin : g_body
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign m_in   = m_reg[j-1];
        end

        always_comb
        begin
            rem_ext = DB'(rem_in);
            tsub    = DB'(m_in) << K;
            q_next  = q_in;
            if (rem_ext >= tsub)
            begin
                rem_next  = NB'(rem_ext - tsub);
                q_next[K] = 1'b1;
            end
            else
            begin
                rem_next = rem_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                q_reg[j]   <= q_next;
                m_reg[j]   <= m_in;
            end
        end
    end

    assign quo = q_reg[NS-1];

endmodule

// ===== rtl/vec4_alu.sv =====
// ----------------------------------------------------------------------------
// vec4_alu: four-component signed fixed-point vector unit
// Scale, add, subtract, magnitude, normalize, dot and cross on Q16.16 items.
// ----------------------------------------------------------------------------
// path: an accepted item passes 4 product and merge stages, the 32-stage square
//   root and the 17-stage normalize divider, then the output register
// throughput: one item per cycle unless stalled; all operations share a path
// a stalled result freezes the whole pipeline, and the input stalls with it
// reset clears the stage valid bits and the output valid; data is not reset
module vec4_alu
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_stall,
    input  v4alu_pkg::op_t      op_data,
    output logic                res_valid,
    input  logic                res_stall,
    output v4alu_pkg::res_t     res_data
);

    localparam int QW   = v4alu_pkg::QW;
    localparam int LAST = v4alu_pkg::ST_LAST;

    // per-item data that travels alongside the arithmetic
    typedef struct packed {
        logic [2:0]                         cmd;
        v4alu_pkg::sat_t [3:0]              addsub;
        logic [3:0]                         neg;
        logic [3:0][QW-1:0]                 mag;
        v4alu_pkg::sat_t [3:0]              vec;
        v4alu_pkg::sat_t                    sc;
        logic [v4alu_pkg::ROOT_BITS:0]      root;
    } side_t;

    logic                 en;
    logic [LAST:1]        valid_reg;
    side_t                side_reg  [1:LAST];
    side_t                side_next [1:LAST];
    logic                 out_valid_reg;
    v4alu_pkg::res_t      out_reg, out_next;

    logic signed [QW-1:0] a_v [4];
    logic signed [QW-1:0] b_v [4];

    logic signed [v4alu_pkg::DIFF_BITS-1:0] lane_d   [4];
    v4alu_pkg::sat_t                        lane_res [4];

    // merge tree over the lane differences
    logic signed [v4alu_pkg::DIFF_BITS:0]   pair01_reg, pair23_reg;
    logic signed [v4alu_pkg::SUM_BITS-1:0]  total_reg;
    logic signed [v4alu_pkg::SUM_BITS-1:0]  total_shr;

    logic [v4alu_pkg::ROOT_BITS:0]          root;
    logic [v4alu_pkg::DIV_STEPS-1:0]        quo [4];

    // whole pipeline moves unless a finished item is held at the output
    assign en       = !(out_valid_reg && res_stall);
    assign op_stall = !en;

    assign a_v[0] = op_data.a_x;
    assign a_v[1] = op_data.a_y;
    assign a_v[2] = op_data.a_z;
    assign a_v[3] = op_data.a_w;
    assign b_v[0] = op_data.b_x;
    assign b_v[1] = op_data.b_y;
    assign b_v[2] = op_data.b_z;
    assign b_v[3] = op_data.b_w;

    // operand routing into the four lanes
    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        localparam int I1 = (i + 1) % 3;
        localparam int I2 = (i + 2) % 3;
        logic signed [QW-1:0] x0, y0, x1, y1;

        always_comb
        begin
            x0 = '0;
            y0 = '0;
            x1 = '0;
            y1 = '0;
            case (op_data.cmd)
                v4alu_pkg::CMD_SCALE:
                begin
                    x0 = op_data.scalar_in;
                    y0 = a_v[i];
                end
                v4alu_pkg::CMD_MAG, v4alu_pkg::CMD_NORM:
                begin
                    x0 = a_v[i];
                    y0 = a_v[i];
                end
                v4alu_pkg::CMD_DOT:
                begin
                    x0 = a_v[i];
                    y0 = b_v[i];
                end
                v4alu_pkg::CMD_CROSS:
                begin
                    // w lane stays at zero for cross
                    if (i < 3)
                    begin
                        x0 = a_v[I1];
                        y0 = b_v[I2];
                        x1 = a_v[I2];
                        y1 = b_v[I1];
                    end
                end
                default:
                begin
                    x0 = '0;
                end
            endcase
        end

        v4alu_lane u_lane
        (
            .clk  (clk),
            .en   (en),
            .x0   (x0),
            .y0   (y0),
            .x1   (x1),
            .y1   (y1),
            .diff (lane_d[i]),
            .res  (lane_res[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pair01_reg <= (v4alu_pkg::DIFF_BITS+1)'(lane_d[0])
                        + (v4alu_pkg::DIFF_BITS+1)'(lane_d[1]);
            pair23_reg <= (v4alu_pkg::DIFF_BITS+1)'(lane_d[2])
                        + (v4alu_pkg::DIFF_BITS+1)'(lane_d[3]);
            total_reg  <= v4alu_pkg::SUM_BITS'(pair01_reg)
                        + v4alu_pkg::SUM_BITS'(pair23_reg);
        end
    end

    assign total_shr = total_reg >>> v4alu_pkg::FRAC_BITS;

    // sum of squares is non-negative for magnitude and normalize
    v4alu_sqrt u_sqrt
    (
        .clk  (clk),
        .en   (en),
        .op   (total_reg[2*v4alu_pkg::ROOT_BITS:0]),
        .root (root)
    );

    for (genvar i = 0; i < 4; i++)
    begin : g_div
        v4alu_div u_div
        (
            .clk (clk),
            .en  (en),
            .num (side_reg[v4alu_pkg::ST_ROOT].mag[i]),
            .den (root),
            .quo (quo[i])
        );
    end

    // side data per stage: loaded at acceptance, filled in as results appear
    always_comb
    begin
        for (int k = 1; k <= LAST; k++)
        begin
            if (k == 1)
            begin
                side_next[k]     = '0;
                side_next[k].cmd = op_data.cmd;
                for (int i = 0; i < 4; i++)
                begin
                    if (op_data.cmd == v4alu_pkg::CMD_SUB)
                    begin
                        side_next[k].addsub[i] = v4alu_pkg::sat_q(
                            v4alu_pkg::SAT_BITS'(a_v[i]) - v4alu_pkg::SAT_BITS'(b_v[i]));
                    end
                    else
                    begin
                        side_next[k].addsub[i] = v4alu_pkg::sat_q(
                            v4alu_pkg::SAT_BITS'(a_v[i]) + v4alu_pkg::SAT_BITS'(b_v[i]));
                    end
                    side_next[k].neg[i] = a_v[i][QW-1];
                    side_next[k].mag[i] = a_v[i][QW-1] ? QW'(-a_v[i]) : QW'(a_v[i]);
                end
            end
            else
            begin
                side_next[k] = side_reg[k-1];
            end

            if (k == v4alu_pkg::ST_LANE)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (side_reg[k-1].cmd == v4alu_pkg::CMD_ADD
                        || side_reg[k-1].cmd == v4alu_pkg::CMD_SUB)
                    begin
                        side_next[k].vec[i] = side_reg[k-1].addsub[i];
                    end
                    else
                    begin
                        side_next[k].vec[i] = lane_res[i];
                    end
                end
            end

            if (k == v4alu_pkg::ST_DOT)
            begin
                side_next[k].sc = v4alu_pkg::sat_q(v4alu_pkg::SAT_BITS'(total_shr));
            end

            if (k == v4alu_pkg::ST_ROOT + 1)
            begin
                side_next[k].root = root;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= LAST; k++)
            begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // final selection and saturation
    always_comb
    begin
        side_t           s;
        v4alu_pkg::sat_t msat;
        logic signed [QW-1:0] nv [4];

        s        = side_reg[LAST];
        msat     = v4alu_pkg::sat_q(v4alu_pkg::SAT_BITS'(s.root));
        out_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            nv[i] = s.neg[i] ? -QW'(quo[i]) : QW'(quo[i]);
        end

        case (s.cmd)
            v4alu_pkg::CMD_SCALE, v4alu_pkg::CMD_ADD, v4alu_pkg::CMD_SUB,
            v4alu_pkg::CMD_CROSS:
            begin
                out_next.r_x           = s.vec[0].val;
                out_next.r_y           = s.vec[1].val;
                out_next.r_z           = s.vec[2].val;
                out_next.r_w           = s.vec[3].val;
                out_next.overflow_flag = s.vec[0].ovf | s.vec[1].ovf
                                       | s.vec[2].ovf | s.vec[3].ovf;
            end
            v4alu_pkg::CMD_MAG:
            begin
                out_next.r_scalar      = msat.val;
                out_next.overflow_flag = msat.ovf;
            end
            v4alu_pkg::CMD_NORM:
            begin
                // zero vector gives all zeros and the divide flag
                if (s.root == '0)
                begin
                    out_next.divide_flag = 1'b1;
                end
                else
                begin
                    out_next.r_x = nv[0];
                    out_next.r_y = nv[1];
                    out_next.r_z = nv[2];
                    out_next.r_w = nv[3];
                end
            end
            v4alu_pkg::CMD_DOT:
            begin
                out_next.r_scalar      = s.sc.val;
                out_next.overflow_flag = s.sc.ovf;
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[LAST-1:1], op_valid};
            out_valid_reg <= valid_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

endmodule

// ===== tb/vec4_alu_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec4_alu_chk: result checker for the vector unit
// Predicts every accepted item in order and compares each result field.
// ----------------------------------------------------------------------------
module vec4_alu_chk
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  logic              op_stall,
    input  v4alu_pkg::op_t    op_data,
    input  logic              res_valid,
    input  logic              res_stall,
    input  v4alu_pkg::res_t   res_data,
    output int                fail_count,
    output int                pending,
    output int                ops_seen,
    output int                ovf_seen,
    output int                div_seen
);

    v4alu_pkg::res_t expected_q[$];

    function automatic logic signed [31:0] clamp(input logic signed [127:0] v,
                                                 inout logic ovf);
        if (v > 128'sd2147483647)
        begin
            ovf = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -128'sd2147483648)
        begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    // integer square root, rounded down, of the sum of squares (the sum fits in 65 bits)
    function automatic logic [127:0] root_of(input v4alu_pkg::op_t d);
        logic signed [127:0] v [4];
        logic [127:0] acc, lo, hi, mid;
        v[0] = d.a_x;
        v[1] = d.a_y;
        v[2] = d.a_z;
        v[3] = d.a_w;
        acc = 128'(v[0] * v[0] + v[1] * v[1] + v[2] * v[2] + v[3] * v[3]);
        // at 2^64 and above the unit treats the root as 2^32
        if (acc >= (128'd1 << 64))
            return 128'd1 << 32;
        lo = 0;
        hi = 128'd1 << 33;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= acc) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic v4alu_pkg::res_t vector_result(input v4alu_pkg::op_t d);
        v4alu_pkg::res_t r;
        logic ovf;
        logic signed [127:0] a [4], b [4], s, t, q;
        logic [127:0] m, mg;
        r = '0;
        ovf = 1'b0;
        a[0] = d.a_x; a[1] = d.a_y; a[2] = d.a_z; a[3] = d.a_w;
        b[0] = d.b_x; b[1] = d.b_y; b[2] = d.b_z; b[3] = d.b_w;
        s = d.scalar_in;
        case (d.cmd)
            v4alu_pkg::CMD_SCALE:
            begin
                r.r_x = clamp((s * a[0]) >>> v4alu_pkg::FRAC_BITS, ovf);
                r.r_y = clamp((s * a[1]) >>> v4alu_pkg::FRAC_BITS, ovf);
                r.r_z = clamp((s * a[2]) >>> v4alu_pkg::FRAC_BITS, ovf);
                r.r_w = clamp((s * a[3]) >>> v4alu_pkg::FRAC_BITS, ovf);
            end
            v4alu_pkg::CMD_ADD:
            begin
                r.r_x = clamp(a[0] + b[0], ovf);
                r.r_y = clamp(a[1] + b[1], ovf);
                r.r_z = clamp(a[2] + b[2], ovf);
                r.r_w = clamp(a[3] + b[3], ovf);
            end
            v4alu_pkg::CMD_SUB:
            begin
                r.r_x = clamp(a[0] - b[0], ovf);
                r.r_y = clamp(a[1] - b[1], ovf);
                r.r_z = clamp(a[2] - b[2], ovf);
                r.r_w = clamp(a[3] - b[3], ovf);
            end
            v4alu_pkg::CMD_MAG:
                r.r_scalar = clamp($signed(root_of(d)), ovf);
            v4alu_pkg::CMD_NORM:
            begin
                m = root_of(d);
                if (m == 0)
                    r.divide_flag = 1'b1;
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        mg = a[i] < 0 ? -a[i] : a[i];
                        q = $signed((mg << v4alu_pkg::FRAC_BITS) / m);
                        t = a[i] < 0 ? -q : q;
                        case (i)
                            0: r.r_x = clamp(t, ovf);
                            1: r.r_y = clamp(t, ovf);
                            2: r.r_z = clamp(t, ovf);
                            default: r.r_w = clamp(t, ovf);
                        endcase
                    end
                end
            end
            v4alu_pkg::CMD_DOT:
                r.r_scalar = clamp((a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3])
                                   >>> v4alu_pkg::FRAC_BITS, ovf);
            v4alu_pkg::CMD_CROSS:
            begin
                r.r_x = clamp((a[1]*b[2] - a[2]*b[1]) >>> v4alu_pkg::FRAC_BITS, ovf);
                r.r_y = clamp((a[2]*b[0] - a[0]*b[2]) >>> v4alu_pkg::FRAC_BITS, ovf);
                r.r_z = clamp((a[0]*b[1] - a[1]*b[0]) >>> v4alu_pkg::FRAC_BITS, ovf);
            end
            default: ;
        endcase
        r.overflow_flag = ovf;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        v4alu_pkg::res_t want;
        int pushed;
        int popped;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending    <= 0;
            ops_seen   <= 0;
            ovf_seen   <= 0;
            div_seen   <= 0;
        end
        else
        begin
            pushed = 0;
            popped = 0;
            if (op_valid && !op_stall)
            begin
                expected_q.push_back(vector_result(op_data));
                ops_seen <= ops_seen + 1;
                pushed = 1;
            end
            if (res_valid && !res_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h", res_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    popped = 1;
                    if (res_data.overflow_flag) ovf_seen <= ovf_seen + 1;
                    if (res_data.divide_flag) div_seen <= div_seen + 1;
                    if (res_data !== want)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("mismatch: exp x%h y%h z%h w%h s%h o%b d%b",
                                     want.r_x, want.r_y, want.r_z, want.r_w,
                                     want.r_scalar, want.overflow_flag,
                                     want.divide_flag);
                            $display("          got x%h y%h z%h w%h s%h o%b d%b",
                                     res_data.r_x, res_data.r_y, res_data.r_z,
                                     res_data.r_w, res_data.r_scalar,
                                     res_data.overflow_flag, res_data.divide_flag);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= pending + pushed - popped;
        end
    end

endmodule

// ===== tb/vec4_alu_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec4_alu_tb: regression bench for the vector unit
// Directed corner items, then random items under three idling patterns and
// a long output hold-off; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module vec4_alu_tb;

    localparam int LATENCY   = 54;
    localparam int WATCHDOG  = 20000;
    localparam int HOLD_LEN  = 300;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             op_valid = 1'b0;
    logic             op_stall;
    v4alu_pkg::op_t   op_data = '0;
    logic             res_valid;
    logic             res_stall = 1'b0;
    v4alu_pkg::res_t  res_data;
    int               fail_count, pending, ops_seen, ovf_seen, div_seen;

    // idling rates in percent, changed by phase
    int    send_idle = 0;
    int    recv_idle = 0;
    logic  hold_req = 1'b0;
    int    idle_cycles = 0;

    always #1 clk = ~clk;

    vec4_alu u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_data   (op_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    vec4_alu_chk u_chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (op_valid),
        .op_stall   (op_stall),
        .op_data    (op_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .fail_count (fail_count),
        .pending    (pending),
        .ops_seen   (ops_seen),
        .ovf_seen   (ovf_seen),
        .div_seen   (div_seen)
    );

    // receiver: random stall, or a long hold-off when asked
    always @(posedge clk)
    begin
        int n;
        if (hold_req)
        begin
            res_stall <= 1'b1;
            for (n = 0; n < HOLD_LEN; n++)
                @(posedge clk);
            res_stall <= 1'b0;
            hold_req  <= 1'b0;
        end
        else
            res_stall <= ($urandom_range(99) < recv_idle);
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((op_valid && !op_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(1) ? 32'h00010000 : 32'hffff0000;
            3: return $signed($urandom_range(2047)) - 1024;
            4: return {{8{$urandom_range(1) ? 1'b1 : 1'b0}}, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // present one item and hold it until it is taken
    task automatic send_item(input v4alu_pkg::op_t d);
        while ($urandom_range(99) < send_idle)
        begin
            op_valid <= 1'b0;
            @(posedge clk);
        end
        op_valid <= 1'b1;
        op_data  <= d;
        @(posedge clk);
        while (op_stall)
            @(posedge clk);
    endtask

    task automatic send_random(input int count);
        v4alu_pkg::op_t d;
        for (int i = 0; i < count; i++)
        begin
            d = {3'($urandom_range(7)), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
            // mostly the defined operations, unknown code now and then
            if (d.cmd == 3'd7 && $urandom_range(3) != 0)
                d.cmd = 3'($urandom_range(6));
            send_item(d);
        end
    endtask

    task automatic send_vec(input v4alu_pkg::cmd_t c, input logic [31:0] ax, ay, az, aw,
                            bx, by, bz, bw, sc);
        send_item({c, ax, ay, az, aw, bx, by, bz, bw, sc});
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each operation, extremes, zero normalize, unknown code
        send_vec(v4alu_pkg::CMD_SCALE, 1, -1, 32'h7fffffff, 32'h80000000,
                 0, 0, 0, 0, 32'h00010000);
        send_vec(v4alu_pkg::CMD_SCALE, 32'h7fffffff, 32'h80000000, 3, -3,
                 0, 0, 0, 0, 32'h80000000);
        send_vec(v4alu_pkg::CMD_ADD, 32'h7fffffff, 32'h80000000, 5, -5, 1, -1, 7, 5, 0);
        send_vec(v4alu_pkg::CMD_SUB, 32'h80000000, 32'h7fffffff, 0, 9,
                 1, -1, 32'h80000000, 9, 0);
        send_vec(v4alu_pkg::CMD_MAG, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0, 0, 0);
        send_vec(v4alu_pkg::CMD_MAG, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 0, 0, 0, 0, 0);
        send_vec(v4alu_pkg::CMD_MAG, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0, 0, 0, 0);
        send_vec(v4alu_pkg::CMD_NORM, 0, 0, 0, 0, 1, 2, 3, 4, 5);
        send_vec(v4alu_pkg::CMD_NORM, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        send_vec(v4alu_pkg::CMD_NORM, -3, 4, 0, 0, 0, 0, 0, 0, 0);
        send_vec(v4alu_pkg::CMD_NORM, 32'h80000000, 0, 0, 0, 0, 0, 0, 0, 0);
        send_vec(v4alu_pkg::CMD_DOT, 32'h00010000, 32'h00020000, 32'h00030000,
                 32'h00040000, 32'hffff0000, 32'h00010000, 32'h00010000,
                 32'h00010000, 0);
        send_vec(v4alu_pkg::CMD_DOT, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 0);
        send_vec(v4alu_pkg::CMD_DOT, 32'h7fffffff, 0, 0, 0, 32'h80000000, 0, 0, 0, 0);
        send_vec(v4alu_pkg::CMD_DOT, -1, 0, 0, 0, 1, 0, 0, 0, 0);
        send_vec(v4alu_pkg::CMD_CROSS, 32'h00010000, 0, 0, 7, 0, 32'h00010000, 0, 9, 0);
        send_vec(v4alu_pkg::CMD_CROSS, 32'h80000000, 32'h7fffffff, 32'h80000000, 0,
                 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0);
        send_item({3'd7, {9{32'hffffffff}}});

        // sender idles lightly, receiver heavily
        send_idle = 7;
        recv_idle = 56;
        send_random(400);

        // long output hold-off while items keep coming, so the pipe fills
        hold_req <= 1'b1;
        recv_idle = 0;
        send_idle = 0;
        send_random(150);

        send_idle = 56;
        recv_idle = 7;
        send_random(400);

        send_idle = 0;
        recv_idle = 0;
        send_random(350);

        op_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("covered %0d items across all seven operations and the unknown code,",
                 ops_seen);
        $display("%0d saturated results, %0d zero-vector normalizes, stalls on both sides",
                 ovf_seen, div_seen);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
